FILE: sv/tkst_pkg.sv
// Shared types, constants and helper functions of the top-k sorted insertion table.
package tkst_pkg;

    // Table geometry.
    localparam int ENTRIES    = 10;
    localparam int NAME_CHARS = 6;
    localparam int NAME_BYTES = 6;

    // Field widths.
    localparam int NAME_W  = 8 * NAME_BYTES;
    localparam int SCORE_W = 32;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int REQ_W   = 2;

    // Input item layout in s_tdata, lowest bit first.
    localparam int S_NAME_LSB  = 0;
    localparam int S_SCORE_LSB = S_NAME_LSB + NAME_W;
    localparam int S_IDX_LSB   = S_SCORE_LSB + SCORE_W;
    localparam int S_USED_W    = S_IDX_LSB + IDX_W;
    localparam int S_DATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Result item layout in m_tdata, lowest bit first.
    localparam int M_QUAL_LSB  = 0;
    localparam int M_RANK_LSB  = M_QUAL_LSB + 1;
    localparam int M_VALID_LSB = M_RANK_LSB + CNT_W;
    localparam int M_NAME_LSB  = M_VALID_LSB + 1;
    localparam int M_SCORE_LSB = M_NAME_LSB + NAME_W;
    localparam int M_CNT_LSB   = M_SCORE_LSB + SCORE_W;
    localparam int M_USED_W    = M_CNT_LSB + CNT_W;
    localparam int M_DATA_W    = ((M_USED_W + 7) / 8) * 8;

    // Request kinds; the fourth code is unused and leaves the table unchanged.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    // One stored pair.
    typedef struct packed {
        logic [NAME_W-1:0]         name;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // Per-cell control from the table controller.
    typedef struct packed {
        logic ins_en;   // an insert item is being accepted this cycle
        logic occupied; // this cell holds a stored pair
    } cell_ctrl_t;

    // Keep the first NAME_CHARS bytes up to the first zero byte; the rest reads as zero.
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              keep;
        res  = '0;
        keep = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++) begin
            keep = keep && (raw[8*i +: 8] != 8'd0) && (i < NAME_CHARS);
            if (keep) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/tkst_cell.sv
// One rank cell: holds a pair, compares it with the new score and shifts or loads on insert.
module tkst_cell
    import tkst_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,  // cleaned pair being inserted
    input  logic       prev_gt,    // the cell above outranks the new pair
    input  entry_t     prev_entry, // pair held by the cell above
    output logic       gt,         // this cell outranks the new pair
    output entry_t     entry       // pair held by this cell
);

    entry_t entry_reg;
    entry_t entry_next;

    // A stored pair outranks the new one only when its score is strictly higher.
    assign gt    = ctrl.occupied && (entry_reg.score > new_entry.score);
    assign entry = entry_reg;

    // Cells that outrank keep their pair, the first that does not loads the new one,
    // and the rest take the pair from the cell above.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins_en && !gt) begin
            if (prev_gt) begin
                entry_next = new_entry;
            end else begin
                entry_next = prev_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: sv/top_k_sorted_insert_table_top.sv
// Top level of the top-k sorted insertion table: cell chain, count and result register.
//
// Usage: the block keeps up to ENTRIES (name, score) pairs in descending score
// order, one pair per cell of a chain of rank cells. A request arrives on the
// s_ channel as one item: s_tuser carries the request kind (insert, read,
// clear) and s_tdata the name, score and read index. Every request gives exactly
// one result item on the m_ channel with the qualify flag, placed rank, read
// pair and the entry count after the request.
// The result of an accepted item is registered and shown from the next cycle on.
// Throughput is one item per cycle while the receiver takes results, set by the
// parallel compare in every cell and the one-step shift insert along the chain.
// The result register parts the two sides, so a new item is taken in the same
// cycle that the previous result is taken. When the receiver stalls, the result
// stays on m_tdata and s_tready falls until it is taken.
// Reset empties the table (the count goes to zero) and drops any pending result
// item; the stored pairs themselves are not cleared.
module top_k_sorted_insert_table_top
    import tkst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // player_name [47:0], score [79:48], read_index [85:80], zero pad [87:86]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  logic [REQ_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // qualified [0], placed_rank [7:1], entry_valid [8], entry_name [56:9],
    // entry_score [88:57], entry_count [95:89]
    output logic [M_DATA_W-1:0] m_tdata
);

    logic                 accept;
    logic [IDX_W-1:0]     read_index;
    entry_t               new_entry;
    cell_ctrl_t           ctrl     [ENTRIES];
    logic                 gt_vec   [ENTRIES];
    entry_t               cell_ent [ENTRIES];
    logic                 prev_gt  [ENTRIES];
    entry_t               prev_ent [ENTRIES];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [M_DATA_W-1:0]  m_tdata_next;

    logic [CNT_W-1:0]     rank;
    logic                 qualified;
    logic                 rd_valid;
    entry_t               rd_entry;

    // Input handshake: take an item whenever the result register is free or emptying.
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign read_index = s_tdata[S_IDX_LSB +: IDX_W];
    assign new_entry.name  = clean_name(s_tdata[S_NAME_LSB +: NAME_W]);
    assign new_entry.score = $signed(s_tdata[S_SCORE_LSB +: SCORE_W]);

    // Chain of rank cells; the head cell sees an outranking neighbour above it.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        assign ctrl[i].ins_en   = accept && (s_tuser == REQ_INSERT);
        assign ctrl[i].occupied = (count_reg > CNT_W'(i));
        if (i == 0) begin : g_head
            assign prev_gt[i]  = 1'b1;
            assign prev_ent[i] = new_entry;
        end else begin : g_link
            assign prev_gt[i]  = gt_vec[i-1];
            assign prev_ent[i] = cell_ent[i-1];
        end
        tkst_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[i]),
            .new_entry  (new_entry),
            .prev_gt    (prev_gt[i]),
            .prev_entry (prev_ent[i]),
            .gt         (gt_vec[i]),
            .entry      (cell_ent[i])
        );
    end

    // The outranking cells form a prefix; the rank is the first cell that does not outrank.
    always_comb begin
        rank = CNT_W'(ENTRIES);
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!gt_vec[i]) begin
                rank = CNT_W'(i);
            end
        end
    end

    // A full table qualifies a score only strictly above its lowest pair.
    assign qualified = (count_reg < CNT_W'(ENTRIES)) ||
                       (new_entry.score > cell_ent[ENTRIES-1].score);

    // Read port: select the cell at the requested rank.
    assign rd_valid = (CNT_W'(read_index) < count_reg);
    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (read_index == IDX_W'(i)) begin
                rd_entry = cell_ent[i];
            end
        end
    end

    // Count update and result item assembly.
    always_comb begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            unique case (s_tuser)
                REQ_INSERT: begin
                    if (count_reg < CNT_W'(ENTRIES)) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    m_tdata_next[M_QUAL_LSB]            = qualified;
                    m_tdata_next[M_RANK_LSB +: CNT_W]   = rank;
                end
                REQ_READ: begin
                    if (rd_valid) begin
                        m_tdata_next[M_VALID_LSB]            = 1'b1;
                        m_tdata_next[M_NAME_LSB +: NAME_W]   = rd_entry.name;
                        m_tdata_next[M_SCORE_LSB +: SCORE_W] = rd_entry.score;
                    end
                end
                REQ_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
            m_tdata_next[M_CNT_LSB +: CNT_W] = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/tkst_checker.sv
// Port-level checks of the top-k sorted insertion table and the bind that attaches them.
module tkst_checker
    import tkst_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Every accepted item shows its result in the next cycle.
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("no result one cycle after an accepted item");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // The count never exceeds the table size.
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_CNT_LSB +: CNT_W] <= CNT_W'(ENTRIES)))
        else $error("entry count above table size");

    // A qualifying insert is always placed, and the table then holds at least one pair.
    a_qual_placed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[M_QUAL_LSB]) |->
        ((m_tdata[M_RANK_LSB +: CNT_W] < CNT_W'(ENTRIES)) &&
         (m_tdata[M_CNT_LSB +: CNT_W] != '0)))
        else $error("qualified insert not placed");

endmodule

bind top_k_sorted_insert_table_top tkst_checker u_tkst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
